[hdl/rge_pkg.sv]
// rge_pkg: shared widths, constants, reciprocal tables and types for the
// rotated gaussian evaluator; no dependencies
package rge_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DATA_W  = 32;
  localparam int ROT_W   = 19;
  localparam int SIG_W   = 31;
  localparam int ADDR_W  = 5;
  localparam int CS_W    = 30;
  localparam int MAG_W   = 62;
  localparam int QUO_W   = 32;
  localparam int SQ_W    = 35;
  localparam int E_W     = 36;
  localparam int RECIP_SH = 34;
  localparam int RECIP_W  = 35;
  localparam int TRIG_TERMS = 10;
  localparam int EXP_TERMS  = 12;
  localparam int KQ_BITS    = 7;

  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] TWO_PI_Q30  = 34'd6746518853;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [27:0] LN2_Q28     = 28'd186065280;
  localparam logic [30:0] ONE_Q30     = 31'h40000000;
  localparam logic [5:0]  K_LIMIT     = 6'd34;

  localparam logic [8:0] SIN_DIV [TRIG_TERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
  localparam logic [8:0] COS_DIV [TRIG_TERMS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};
  localparam logic [3:0] EXP_DIV [EXP_TERMS] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12};

  localparam logic [RECIP_W-1:0] SIN_RECIP [TRIG_TERMS] = '{
    RECIP_W'((64'd1 << RECIP_SH) / 64'd6),   RECIP_W'((64'd1 << RECIP_SH) / 64'd20),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd42),  RECIP_W'((64'd1 << RECIP_SH) / 64'd72),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd110), RECIP_W'((64'd1 << RECIP_SH) / 64'd156),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd210), RECIP_W'((64'd1 << RECIP_SH) / 64'd272),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd342), RECIP_W'((64'd1 << RECIP_SH) / 64'd420)};
  localparam logic [RECIP_W-1:0] COS_RECIP [TRIG_TERMS] = '{
    RECIP_W'((64'd1 << RECIP_SH) / 64'd2),   RECIP_W'((64'd1 << RECIP_SH) / 64'd12),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd30),  RECIP_W'((64'd1 << RECIP_SH) / 64'd56),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd90),  RECIP_W'((64'd1 << RECIP_SH) / 64'd132),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd182), RECIP_W'((64'd1 << RECIP_SH) / 64'd240),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd306), RECIP_W'((64'd1 << RECIP_SH) / 64'd380)};
  localparam logic [RECIP_W-1:0] EXP_RECIP [EXP_TERMS] = '{
    RECIP_W'((64'd1 << RECIP_SH) / 64'd1),  RECIP_W'((64'd1 << RECIP_SH) / 64'd2),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd3),  RECIP_W'((64'd1 << RECIP_SH) / 64'd4),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd5),  RECIP_W'((64'd1 << RECIP_SH) / 64'd6),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd7),  RECIP_W'((64'd1 << RECIP_SH) / 64'd8),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd9),  RECIP_W'((64'd1 << RECIP_SH) / 64'd10),
    RECIP_W'((64'd1 << RECIP_SH) / 64'd11), RECIP_W'((64'd1 << RECIP_SH) / 64'd12)};

  typedef enum logic [2:0] {
    REG_AMPLITUDE = 3'd0,
    REG_CENTER_X  = 3'd1,
    REG_CENTER_Y  = 3'd2,
    REG_SIGMA_X   = 3'd3,
    REG_SIGMA_Y   = 3'd4,
    REG_ROTATION  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    T_IDLE, T_REDUCE, T_FOLD, T_SQUARE, T_MUL, T_RECIP, T_ACC, T_DONE
  } trig_state_t;

  typedef struct packed {
    logic                   busy;
    logic signed [CS_W-1:0] sin_q;
    logic signed [CS_W-1:0] cos_q;
  } trig_out_t;

endpackage

[hdl/rge_trig.sv]
// rge_trig: sequential sine and cosine of the rotation angle in Q.28,
// rerun after each rotation write; depends on rge_pkg
module rge_trig #(
  parameter int FRAC_BITS = rge_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rge_pkg::ROT_W-1:0]  rot,
  output rge_pkg::trig_out_t         trig_o
);
  import rge_pkg::*;

  localparam int RW = ROT_W + 30 - FRAC_BITS;
  localparam int MW = (RW > 34) ? RW : 34;
  localparam logic signed [CS_W-1:0] CS_ONE = CS_W'(1 << 28);

  trig_state_t state, state_next;
  logic [MW-1:0]  rmag, rmag_next;
  logic           rneg, rneg_next;
  logic           sneg, sneg_next;
  logic           cneg, cneg_next;
  logic [30:0]    m, m_next;
  logic [31:0]    x2, x2_next;
  logic [30:0]    ts, ts_next, tc, tc_next;
  logic [32:0]    ps, ps_next, pc, pc_next;
  logic [32:0]    qs, qs_next, qc, qc_next;
  logic signed [33:0] s, s_next, c, c_next;
  logic [3:0]     k, k_next;
  logic signed [CS_W-1:0] sin_q, sin_q_next, cos_q, cos_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      sin_q <= '0;
      cos_q <= CS_ONE;
    end else begin
      state <= state_next;
      sin_q <= sin_q_next;
      cos_q <= cos_q_next;
    end
  end

  always_ff @(posedge clk) begin
    rmag <= rmag_next;
    rneg <= rneg_next;
    sneg <= sneg_next;
    cneg <= cneg_next;
    m    <= m_next;
    x2   <= x2_next;
    ts   <= ts_next;
    tc   <= tc_next;
    ps   <= ps_next;
    pc   <= pc_next;
    qs   <= qs_next;
    qc   <= qc_next;
    s    <= s_next;
    c    <= c_next;
    k    <= k_next;
  end

  always_comb begin
    logic [ROT_W-1:0] rot_mag;
    logic [33:0] r34, m1, m2;
    logic        neg1;
    logic [61:0] msq;
    logic [62:0] pms, pmc;
    logic [67:0] rcs, rcc;
    logic [41:0] rms, rmc;
    logic [31:0] tsn, tcn;
    logic [30:0] sv, cv;
    logic [31:0] sr, cr;
    state_next = state;
    rmag_next = rmag;
    rneg_next = rneg;
    sneg_next = sneg;
    cneg_next = cneg;
    m_next = m;
    x2_next = x2;
    ts_next = ts;
    tc_next = tc;
    ps_next = ps;
    pc_next = pc;
    qs_next = qs;
    qc_next = qc;
    s_next = s;
    c_next = c;
    k_next = k;
    sin_q_next = sin_q;
    cos_q_next = cos_q;
    rot_mag = rot[ROT_W-1] ? ROT_W'(-rot) : rot;
    r34 = rmag[33:0];
    neg1 = rneg && (r34 != '0);
    m1 = r34;
    if (r34 > PI_Q30) begin
      m1 = TWO_PI_Q30 - r34;
      neg1 = !rneg;
    end
    m2 = (m1 > HALF_PI_Q30) ? (PI_Q30 - m1) : m1;
    msq = 62'(m) * 62'(m);
    pms = 63'(ts) * 63'(x2);
    pmc = 63'(tc) * 63'(x2);
    rcs = 68'(ps) * 68'(SIN_RECIP[k]);
    rcc = 68'(pc) * 68'(COS_RECIP[k]);
    rms = 42'(ps) - 42'(qs) * 42'(SIN_DIV[k]);
    rmc = 42'(pc) - 42'(qc) * 42'(COS_DIV[k]);
    tsn = 32'(qs) + ((rms >= 42'(SIN_DIV[k])) ? 32'd1 : 32'd0);
    tcn = 32'(qc) + ((rmc >= 42'(COS_DIV[k])) ? 32'd1 : 32'd0);
    sv = (s < 0) ? '0 : ((s > 34'sd1073741824) ? ONE_Q30 : s[30:0]);
    cv = (c < 0) ? '0 : ((c > 34'sd1073741824) ? ONE_Q30 : c[30:0]);
    sr = (32'(sv) + 32'd2) >> 2;
    cr = (32'(cv) + 32'd2) >> 2;
    unique case (state)
      T_IDLE: ;
      T_REDUCE: begin
        if (rmag >= MW'(TWO_PI_Q30)) begin
          rmag_next = rmag - MW'(TWO_PI_Q30);
        end else begin
          state_next = T_FOLD;
        end
      end
      T_FOLD: begin
        sneg_next = neg1;
        cneg_next = m1 > HALF_PI_Q30;
        m_next = m2[30:0];
        state_next = T_SQUARE;
      end
      T_SQUARE: begin
        x2_next = msq[61:30];
        ts_next = m;
        tc_next = ONE_Q30;
        s_next = signed'(34'(m));
        c_next = signed'(34'(ONE_Q30));
        k_next = '0;
        state_next = T_MUL;
      end
      T_MUL: begin
        ps_next = pms[62:30];
        pc_next = pmc[62:30];
        state_next = T_RECIP;
      end
      T_RECIP: begin
        qs_next = rcs[66:34];
        qc_next = rcc[66:34];
        state_next = T_ACC;
      end
      T_ACC: begin
        ts_next = tsn[30:0];
        tc_next = tcn[30:0];
        // odd terms subtract
        if (!k[0]) begin
          s_next = s - signed'(34'(tsn[30:0]));
          c_next = c - signed'(34'(tcn[30:0]));
        end else begin
          s_next = s + signed'(34'(tsn[30:0]));
          c_next = c + signed'(34'(tcn[30:0]));
        end
        if (k == 4'(TRIG_TERMS - 1)) begin
          state_next = T_DONE;
        end else begin
          k_next = k + 4'd1;
          state_next = T_MUL;
        end
      end
      T_DONE: begin
        sin_q_next = sneg ? -signed'(CS_W'(sr)) : signed'(CS_W'(sr));
        cos_q_next = cneg ? -signed'(CS_W'(cr)) : signed'(CS_W'(cr));
        state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
    if (start) begin
      rmag_next = MW'(rot_mag) << (30 - FRAC_BITS);
      rneg_next = rot[ROT_W-1];
      state_next = T_REDUCE;
    end
  end

  assign trig_o.busy  = (state != T_IDLE);
  assign trig_o.sin_q = sin_q;
  assign trig_o.cos_q = cos_q;

  ap_cos_range: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> ((cos_q <= CS_ONE) && (cos_q >= -CS_ONE)))
    else $error("cosine out of range");
  ap_done_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == T_DONE) && !start) |=> (state == T_IDLE))
    else $error("trig sequencer did not finish");

endmodule

[hdl/rge_div.sv]
// rge_div: pipelined restoring divider, one quotient bit per stage,
// quotient clamped to all ones on overflow; depends on rge_pkg
module rge_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [rge_pkg::MAG_W-1:0]  num,
  input  logic [rge_pkg::SIG_W-1:0]  den,
  output logic                       out_vld,
  output logic [rge_pkg::QUO_W-1:0]  quo
);
  import rge_pkg::*;

  logic             vld  [QUO_W+1];
  logic             ovf  [QUO_W+1];
  logic [SIG_W-1:0] rem  [QUO_W+1];
  logic [QUO_W-1:0] low  [QUO_W+1];
  logic [QUO_W-1:0] qacc [QUO_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0]  <= SIG_W'(num[MAG_W-1:QUO_W]) >= den;
      rem[0]  <= SIG_W'(num[MAG_W-1:QUO_W]);
      low[0]  <= num[QUO_W-1:0];
      qacc[0] <= '0;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_bit
    logic [SIG_W:0] trial;
    logic           ge;
    assign trial = {rem[j], low[j][QUO_W-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf[j+1]  <= ovf[j];
        rem[j+1]  <= ge ? SIG_W'(trial - {1'b0, den}) : SIG_W'(trial);
        low[j+1]  <= {low[j][QUO_W-2:0], 1'b0};
        qacc[j+1] <= {qacc[j][QUO_W-2:0], ge};
      end
    end
  end

  assign out_vld = vld[QUO_W];
  assign quo     = ovf[QUO_W] ? '1 : qacc[QUO_W];

endmodule

[hdl/rge_exp.sv]
// rge_exp: pipelined amplitude * exp(-e): split e by ln2, taylor series for
// the remainder, scale by 2^-k with rounding; depends on rge_pkg
module rge_exp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [rge_pkg::E_W-1:0]     e,
  input  logic [rge_pkg::DATA_W-1:0]  amplitude,
  output logic                        out_vld,
  output logic [rge_pkg::DATA_W-1:0]  value
);
  import rge_pkg::*;

  typedef struct packed {
    logic               zero;
    logic [5:0]         sh;
    logic [29:0]        r;
    logic signed [32:0] acc;
  } ctx_t;

  // split stage: e = k*ln2 + rem
  logic               kv   [KQ_BITS+1];
  logic               kz   [KQ_BITS+1];
  logic [33:0]        krem [KQ_BITS+1];
  logic [KQ_BITS-1:0] kq   [KQ_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      kv[0] <= 1'b0;
    end else if (en) begin
      kv[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kz[0]   <= e[E_W-1:34] != '0;
      krem[0] <= e[33:0];
      kq[0]   <= '0;
    end
  end

  for (genvar i = 0; i < KQ_BITS; i++) begin : g_ksplit
    localparam logic [33:0] SUB = 34'(LN2_Q28) << (KQ_BITS - 1 - i);
    logic ge;
    assign ge = krem[i] >= SUB;

    always_ff @(posedge clk) begin
      if (rst) begin
        kv[i+1] <= 1'b0;
      end else if (en) begin
        kv[i+1] <= kv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kz[i+1]   <= kz[i];
        krem[i+1] <= ge ? (krem[i] - SUB) : krem[i];
        kq[i+1]   <= {kq[i][KQ_BITS-2:0], ge};
      end
    end
  end

  // taylor terms, three stages each
  logic        vc [EXP_TERMS+1];
  ctx_t        cc [EXP_TERMS+1];
  logic [30:0] tc [EXP_TERMS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc[0] <= 1'b0;
    end else if (en) begin
      vc[0] <= kv[KQ_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc[0].zero <= kz[KQ_BITS] || (kq[KQ_BITS] >= KQ_BITS'(K_LIMIT));
      cc[0].sh   <= 6'(kq[KQ_BITS]) + 6'd30;
      cc[0].r    <= {krem[KQ_BITS][27:0], 2'b00};
      cc[0].acc  <= signed'(33'(ONE_Q30));
      tc[0]      <= ONE_Q30;
    end
  end

  for (genvar n = 0; n < EXP_TERMS; n++) begin : g_term
    logic        va, vb;
    ctx_t        ca, cb;
    logic [30:0] pa, pb, qb;
    logic [60:0] mul_a;
    logic [65:0] mul_b;
    logic [34:0] rm;
    logic [31:0] tn;

    assign mul_a = 61'(tc[n]) * 61'(cc[n].r);
    assign mul_b = 66'(pa) * 66'(EXP_RECIP[n]);
    assign rm    = 35'(pb) - 35'(qb) * 35'(EXP_DIV[n]);
    assign tn    = 32'(qb) + ((rm >= 35'(EXP_DIV[n])) ? 32'd1 : 32'd0);

    always_ff @(posedge clk) begin
      if (rst) begin
        va      <= 1'b0;
        vb      <= 1'b0;
        vc[n+1] <= 1'b0;
      end else if (en) begin
        va      <= vc[n];
        vb      <= va;
        vc[n+1] <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ca <= cc[n];
        pa <= mul_a[60:30];
        cb <= ca;
        pb <= pa;
        qb <= mul_b[64:34];
        cc[n+1].zero <= cb.zero;
        cc[n+1].sh   <= cb.sh;
        cc[n+1].r    <= cb.r;
        // odd terms subtract
        if ((n % 2) == 0) begin
          cc[n+1].acc <= cb.acc - signed'(33'(tn[30:0]));
        end else begin
          cc[n+1].acc <= cb.acc + signed'(33'(tn[30:0]));
        end
        tc[n+1] <= tn[30:0];
      end
    end
  end

  // scale and round
  logic        fv1, fv2;
  logic        fz1;
  logic [5:0]  fsh1;
  logic [62:0] prod1;
  logic [30:0] ev;
  logic [31:0] amag;
  logic [63:0] rnd;
  logic [31:0] res;

  assign ev   = (cc[EXP_TERMS].acc < 0) ? '0 : cc[EXP_TERMS].acc[30:0];
  assign amag = amplitude[DATA_W-1] ? (32'd0 - amplitude) : amplitude;
  assign rnd  = (64'(prod1) + (64'd1 << (fsh1 - 6'd1))) >> fsh1;
  assign res  = fz1 ? 32'd0 : rnd[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv1 <= 1'b0;
      fv2 <= 1'b0;
    end else if (en) begin
      fv1 <= vc[EXP_TERMS];
      fv2 <= fv1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fz1   <= cc[EXP_TERMS].zero;
      fsh1  <= cc[EXP_TERMS].sh;
      prod1 <= 63'(amag) * 63'(ev);
      value <= amplitude[DATA_W-1] ? (32'd0 - res) : res;
    end
  end

  assign out_vld = fv2;

endmodule

[hdl/rotated_gaussian_2d_eval_top.sv]
// rotated_gaussian_2d_eval_top: evaluates a rotated elliptical gaussian
// per point; instantiates rge_trig, rge_div and rge_exp; depends on rge_pkg
//
// Usage
//   Input channel in_valid/in_stall carries one point (x_coord, y_coord)
//   per beat; output channel out_valid/out_stall carries gauss_value.
//   Registers sit on an APB-style port at byte addresses 4*i:
//   amplitude, center_x, center_y, sigma_x, sigma_y, rotation.
//   The delay from the accepting edge to out_valid is set by the 32-stage
//   dividers and the 36-stage exponential series. One beat is accepted per
//   cycle while in_stall is low.
//   A rotation write starts the sine/cosine sequencer, which holds in_stall
//   high while it runs its full-turn reduction steps (none at FRAC_BITS 16,
//   up to 162 at FRAC_BITS 8), its fold and square steps and the series.
//   Reset clears the registers to amplitude 1.0, sigmas 1.0, centres and
//   rotation 0, and empties the pipeline.
//   When the receiver stalls, a skid register takes one more result; after
//   that the whole pipeline holds and in_stall rises, so nothing is lost.
module rotated_gaussian_2d_eval_top #(
  parameter int FRAC_BITS = rge_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rge_pkg::ADDR_W-1:0]   paddr,
  input  logic [rge_pkg::DATA_W-1:0]   pwdata,
  output logic [rge_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rge_pkg::DATA_W-1:0]   x_coord,
  input  logic [rge_pkg::DATA_W-1:0]   y_coord,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rge_pkg::DATA_W-1:0]   gauss_value
);
  import rge_pkg::*;

  // configuration
  logic [DATA_W-1:0] amplitude, center_x, center_y;
  logic [SIG_W-1:0]  sigma_x, sigma_y;
  logic [ROT_W-1:0]  rotation;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= DATA_W'(1) << FRAC_BITS;
      center_x  <= '0;
      center_y  <= '0;
      sigma_x   <= SIG_W'(1) << FRAC_BITS;
      sigma_y   <= SIG_W'(1) << FRAC_BITS;
      rotation  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AMPLITUDE: amplitude <= pwdata;
        REG_CENTER_X:  center_x  <= pwdata;
        REG_CENTER_Y:  center_y  <= pwdata;
        REG_SIGMA_X:   sigma_x   <= pwdata[SIG_W-1:0];
        REG_SIGMA_Y:   sigma_y   <= pwdata[SIG_W-1:0];
        REG_ROTATION:  rotation  <= pwdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_AMPLITUDE: prdata = amplitude;
      REG_CENTER_X:  prdata = center_x;
      REG_CENTER_Y:  prdata = center_y;
      REG_SIGMA_X:   prdata = DATA_W'(sigma_x);
      REG_SIGMA_Y:   prdata = DATA_W'(sigma_y);
      REG_ROTATION:  prdata = DATA_W'(rotation);
      default:       prdata = '0;
    endcase
  end

  // sine and cosine
  trig_out_t trig_o;
  logic      rot_start;

  assign rot_start = cfg_wr && (cfg_idx == REG_ROTATION);

  rge_trig #(.FRAC_BITS(FRAC_BITS)) u_trig (
    .clk    (clk),
    .rst    (rst),
    .start  (rot_start),
    .rot    (pwdata[ROT_W-1:0]),
    .trig_o (trig_o)
  );

  logic signed [CS_W-1:0] sin_c, cos_c;
  assign sin_c = trig_o.sin_q;
  assign cos_c = trig_o.cos_q;

  // pipeline control
  logic en, skid_valid, tail_valid, in_acc;
  logic [DATA_W-1:0] skid_data, tail_data;

  assign en       = !skid_valid;
  assign in_stall = !en || trig_o.busy;
  assign in_acc   = in_valid && !in_stall;

  // front end
  logic v0, v1, v2, v3;
  logic [DATA_W-1:0] x_r, y_r;
  logic signed [32:0] dx, dy;
  logic signed [62:0] pxc, pys, pyc, pxs;
  logic signed [62:0] u_s, v_s;
  logic [62:0] u_abs, v_abs;
  logic [MAG_W-1:0] umag, vmag;

  assign u_s   = pxc + pys;
  assign v_s   = pyc - pxs;
  assign u_abs = u_s[62] ? 63'(-u_s) : 63'(u_s);
  assign v_abs = v_s[62] ? 63'(-v_s) : 63'(v_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= in_acc;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_acc) begin
        x_r <= x_coord;
        y_r <= y_coord;
      end
      dx   <= signed'({x_r[DATA_W-1], x_r}) - signed'({center_x[DATA_W-1], center_x});
      dy   <= signed'({y_r[DATA_W-1], y_r}) - signed'({center_y[DATA_W-1], center_y});
      pxc  <= dx * cos_c;
      pys  <= dy * sin_c;
      pyc  <= dy * cos_c;
      pxs  <= dx * sin_c;
      umag <= u_abs[MAG_W-1:0];
      vmag <= v_abs[MAG_W-1:0];
    end
  end

  // scaled distances
  logic [SIG_W-1:0] sx, sy;
  logic             du_vld, dv_vld;
  logic [QUO_W-1:0] qu, qv;

  assign sx = (sigma_x == '0) ? SIG_W'(1) : sigma_x;
  assign sy = (sigma_y == '0) ? SIG_W'(1) : sigma_y;

  rge_div u_div_u (
    .clk (clk), .rst (rst), .en (en), .in_vld (v3),
    .num (umag), .den (sx), .out_vld (du_vld), .quo (qu)
  );

  rge_div u_div_v (
    .clk (clk), .rst (rst), .en (en), .in_vld (v3),
    .num (vmag), .den (sy), .out_vld (dv_vld), .quo (qv)
  );

  logic v4, v5;
  logic [63:0] squ_full, sqv_full;
  logic [SQ_W-1:0] squ, sqv;
  logic [E_W-1:0] esum;

  assign squ_full = 64'(qu) * 64'(qu);
  assign sqv_full = 64'(qv) * 64'(qv);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= du_vld && dv_vld;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      squ  <= squ_full[63:29];
      sqv  <= sqv_full[63:29];
      esum <= E_W'(squ) + E_W'(sqv);
    end
  end

  rge_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (v5),
    .e         (esum),
    .amplitude (amplitude),
    .out_vld   (tail_valid),
    .value     (tail_data)
  );

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= en && tail_valid;
      end
    end else if (en && tail_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        gauss_value <= skid_data;
      end else if (en) begin
        gauss_value <= tail_data;
      end
    end else if (en && tail_valid) begin
      skid_data <= tail_data;
    end
  end

  ap_rot_stall: assert property (@(posedge clk) disable iff (rst)
    rot_start |=> in_stall)
    else $error("beat accepted during trig update");
  ap_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat ahead of the output register");
  ap_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !skid_valid && tail_valid) |=> skid_valid)
    else $error("result dropped while output stalled");

endmodule
